// ===== hw/rtl/ifr_pkg.sv =====
// ----------------------------------------------------------------------------
// Instruction fetch request package
// Shared widths, defaults and beat types of the instruction fetch stage.
// ----------------------------------------------------------------------------
package ifr_pkg;

    localparam int FIELD_W          = 64;
    localparam int ADDR_BITS_DEF    = 64;
    localparam int INSTR_BITS_DEF   = 64;

    typedef struct packed {
        logic               predict_valid;
        logic [FIELD_W-1:0] predict_pc;
        logic               mem_req_ready;
        logic               mem_data_valid;
        logic [FIELD_W-1:0] mem_data_addr;
        logic [FIELD_W-1:0] mem_data;
        logic               mem_load_fault;
        logic               mem_page_fault;
        logic               flush;
        logic               buffer_enable;
        logic [FIELD_W-1:0] buffer_pc;
        logic [FIELD_W-1:0] buffer_instr;
    } t_fetch_in;

    typedef struct packed {
        logic               req_addr_valid;
        logic [FIELD_W-1:0] req_addr_out;
        logic               resp_ready_out;
        logic [FIELD_W-1:0] fetching_pc;
        logic [FIELD_W-1:0] out_pc;
        logic [FIELD_W-1:0] out_instr;
        logic               out_load_fault;
        logic               out_page_fault;
    } t_fetch_out;

endpackage

// ===== hw/rtl/ifr_in_if.sv =====
// ----------------------------------------------------------------------------
// Fetch input channel
// Valid/ready channel that carries one set of fetch stage inputs per beat.
// ----------------------------------------------------------------------------
interface ifr_in_if;
    import ifr_pkg::*;

    logic      valid;
    logic      ready;
    t_fetch_in data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ifr_out_if.sv =====
// ----------------------------------------------------------------------------
// Fetch output channel
// Valid/ready channel that carries the registered fetch outputs per beat.
// ----------------------------------------------------------------------------
interface ifr_out_if;
    import ifr_pkg::*;

    logic       valid;
    logic       ready;
    t_fetch_out data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ifr_core.sv =====
// ----------------------------------------------------------------------------
// Fetch request state machine
// Holds the request, in-flight and latched instruction state and advances it
// by one step for every accepted input beat.
// ----------------------------------------------------------------------------
module ifr_core #(
    parameter int ADDR_BITS  = ifr_pkg::ADDR_BITS_DEF,
    parameter int INSTR_BITS = ifr_pkg::INSTR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ifr_pkg::t_fetch_in i_beat,
    output ifr_pkg::t_fetch_out o_state
);
    import ifr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE        = 2'd0,
        ST_WAIT_ACCEPT = 2'd1,
        ST_WAIT_RESP   = 2'd2
    } t_state;

    localparam logic [ADDR_BITS-1:0] ADDR_ONES = '1;

    t_state                r_state,  n_state;
    logic                  r_rv,     n_rv;
    logic                  r_rr,     n_rr;
    logic [ADDR_BITS-1:0]  r_ra,     n_ra;
    logic [ADDR_BITS-1:0]  r_fa,     n_fa;
    logic [ADDR_BITS-1:0]  r_pc,     n_pc;
    logic [INSTR_BITS-1:0] r_instr,  n_instr;
    logic                  r_lf,     n_lf;
    logic                  r_pf,     n_pf;

    logic [ADDR_BITS-1:0]  p_pc;
    logic [ADDR_BITS-1:0]  d_addr;
    logic [INSTR_BITS-1:0] d_data;
    logic [ADDR_BITS-1:0]  b_pc;
    logic [INSTR_BITS-1:0] b_instr;
    logic                  next_req;

    assign p_pc     = i_beat.predict_pc[ADDR_BITS-1:0];
    assign d_addr   = i_beat.mem_data_addr[ADDR_BITS-1:0];
    assign d_data   = i_beat.mem_data[INSTR_BITS-1:0];
    assign b_pc     = i_beat.buffer_pc[ADDR_BITS-1:0];
    assign b_instr  = i_beat.buffer_instr[INSTR_BITS-1:0];
    assign next_req = i_beat.predict_valid & ~i_beat.buffer_enable;

    always_comb begin
        n_state = r_state;
        n_rv    = r_rv;
        n_rr    = r_rr;
        n_ra    = r_ra;
        n_fa    = r_fa;
        n_pc    = r_pc;
        n_instr = r_instr;
        n_lf    = r_lf;
        n_pf    = r_pf;

        unique case (r_state)
            ST_IDLE: begin
                n_rv = 1'b0;
                n_rr = 1'b0;
                if (i_beat.buffer_enable) begin
                    n_pc    = b_pc;
                    n_instr = b_instr;
                    n_lf    = 1'b0;
                    n_pf    = 1'b0;
                end else if (i_beat.predict_valid) begin
                    n_state = ST_WAIT_ACCEPT;
                    n_ra    = p_pc;
                    n_rv    = 1'b1;
                end
            end
            ST_WAIT_ACCEPT: begin
                if (i_beat.mem_req_ready) begin
                    n_rv    = next_req;
                    n_ra    = p_pc;
                    n_fa    = r_ra;
                    n_rr    = 1'b1;
                    n_state = ST_WAIT_RESP;
                end else if (i_beat.predict_valid) begin
                    n_ra = p_pc;
                end
            end
            ST_WAIT_RESP: begin
                if (i_beat.mem_data_valid) begin
                    n_pc    = d_addr;
                    n_instr = d_data;
                    n_lf    = i_beat.mem_load_fault;
                    n_pf    = i_beat.mem_page_fault;
                    n_rv    = next_req;
                    if (r_rv) begin
                        if (i_beat.mem_req_ready) begin
                            n_ra = p_pc;
                            n_fa = r_ra;
                        end else begin
                            n_state = ST_WAIT_ACCEPT;
                        end
                    end else if (next_req) begin
                        n_ra    = p_pc;
                        n_state = ST_WAIT_ACCEPT;
                    end else begin
                        n_ra    = ADDR_ONES;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase

        if (i_beat.flush) begin
            n_rv    = 1'b0;
            n_pc    = ADDR_ONES;
            n_instr = '0;
            n_lf    = 1'b0;
            n_pf    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rv    <= 1'b0;
            r_rr    <= 1'b0;
            r_ra    <= ADDR_ONES;
            r_fa    <= '0;
            r_pc    <= ADDR_ONES;
            r_instr <= '0;
            r_lf    <= 1'b0;
            r_pf    <= 1'b0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_rv    <= n_rv;
            r_rr    <= n_rr;
            r_ra    <= n_ra;
            r_fa    <= n_fa;
            r_pc    <= n_pc;
            r_instr <= n_instr;
            r_lf    <= n_lf;
            r_pf    <= n_pf;
        end
    end

    assign o_state.req_addr_valid = r_rv;
    assign o_state.req_addr_out   = FIELD_W'(r_ra);
    assign o_state.resp_ready_out = r_rr;
    assign o_state.fetching_pc    = FIELD_W'(r_fa);
    assign o_state.out_pc         = FIELD_W'(r_pc);
    assign o_state.out_instr      = FIELD_W'(r_instr);
    assign o_state.out_load_fault = r_lf;
    assign o_state.out_page_fault = r_pf;

endmodule

// ===== hw/rtl/ifr_out_reg.sv =====
// ----------------------------------------------------------------------------
// Fetch result register
// Holds one result beat until the sink takes it and reports when a new
// result can be loaded.
// ----------------------------------------------------------------------------
module ifr_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  ifr_pkg::t_fetch_out i_result,
    output logic                o_free,
    ifr_out_if.source           o_out
);
    import ifr_pkg::*;

    logic       r_valid;
    t_fetch_out r_data;

    assign o_free = ~r_valid | o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_data;

endmodule

// ===== hw/rtl/instruction_fetch_request_fsm.sv =====
// ----------------------------------------------------------------------------
// Instruction fetch request stage
// Each accepted input beat loads a result beat holding the state before it.
// Throughput: one beat per cycle while the sink takes each result; the state
// registers update in one step and the result register frees when taken.
// Reset: synchronous, active low; state returns to idle with the request
// address and latched pc all ones, and no result is pending.
// ----------------------------------------------------------------------------
module instruction_fetch_request_fsm #(
    parameter int ADDR_BITS  = ifr_pkg::ADDR_BITS_DEF,
    parameter int INSTR_BITS = ifr_pkg::INSTR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ifr_in_if.sink    i_in,
    ifr_out_if.source o_out
);
    import ifr_pkg::*;

    logic       accept;
    logic       out_free;
    t_fetch_out state;

    assign i_in.ready = out_free;
    assign accept     = i_in.valid & out_free;

    ifr_core #(
        .ADDR_BITS  (ADDR_BITS),
        .INSTR_BITS (INSTR_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_beat   (i_in.data),
        .o_state  (state)
    );

    ifr_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (state),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule
